// File: hdl/nla_pkg.sv
// Shared types and constants for the nested-loop address generator.
package nla_pkg;

    localparam int ADDR_WIDTH   = 24;
    localparam int COUNT_WIDTH  = 16;
    localparam int JUMP_COUNT   = 5;
    localparam int LEVELS       = 4;
    localparam int LEN_FIELD_W  = 16;
    localparam int JUMP_W       = 24;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int ADDR_FIELD_W = 24;
    localparam int PLANE_W      = 4;
    localparam int SEL_W        = 5;
    localparam int PREC_W       = 8;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    typedef enum logic [2:0] {
        JMP_OUTER   = 3'd0,
        JMP_L1      = 3'd1,
        JMP_L2      = 3'd2,
        JMP_L3      = 3'd3,
        JMP_INNER   = 3'd4,
        JMP_RESTART = 3'd5
    } t_jump;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LENGTHS    = 3'd0,
        REG_JUMP_OUTER = 3'd1,
        REG_JUMP_L1    = 3'd2,
        REG_JUMP_L2    = 3'd3,
        REG_JUMP_L3    = 3'd4,
        REG_JUMP_INNER = 3'd5,
        REG_ZZ_SELECT  = 3'd6,
        REG_PRECISIONS = 3'd7
    } t_cfg_reg;

    // one accepted request as seen by the plane stepper
    typedef struct packed {
        logic  fire;
        logic  restart;
        t_jump jump;
    } t_step;

    typedef struct packed {
        logic [SEL_W-1:0]   select;
        logic [PLANE_W-1:0] prec_in;
        logic [PLANE_W-1:0] prec_wt;
    } t_zz_cfg;

endpackage

// File: hdl/nla_nest.sv
// Four-level down-counter nest, jump selection and wrapping address register.
module nla_nest (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic                            i_restart,
    input  logic [nla_pkg::CFG_W-1:0]       i_lengths,
    input  logic [nla_pkg::JUMP_W-1:0]      i_jumps [nla_pkg::JUMP_COUNT],
    output logic [nla_pkg::ADDR_WIDTH-1:0]  o_addr,
    output nla_pkg::t_step                  o_step
);
    import nla_pkg::*;

    logic [COUNT_WIDTH-1:0] r_cnt [LEVELS];
    logic [COUNT_WIDTH-1:0] n_cnt [LEVELS];
    logic [COUNT_WIDTH-1:0] len   [LEVELS];
    logic [LEVELS-1:0]      zero;
    logic [ADDR_WIDTH-1:0]  r_addr;
    logic [ADDR_WIDTH-1:0]  n_addr;
    t_jump                  jump;
    logic [2:0]             jidx;

    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            zero[k] = (r_cnt[k] == '0);
            len[k]  = i_lengths[k*LEN_FIELD_W +: COUNT_WIDTH];
        end
    end

    // deepest level whose inner levels are all exhausted
    always_comb begin
        if (i_restart) begin
            jump = JMP_RESTART;
        end else if (&zero) begin
            jump = JMP_OUTER;
        end else if (&zero[3:1]) begin
            jump = JMP_L1;
        end else if (&zero[3:2]) begin
            jump = JMP_L2;
        end else if (zero[3]) begin
            jump = JMP_L3;
        end else begin
            jump = JMP_INNER;
        end
    end

    always_comb begin
        for (int k = 0; k < LEVELS; k++) begin
            if (i_restart || k >= int'(jump)) begin
                n_cnt[k] = len[k];
            end else if (k + 1 == int'(jump)) begin
                n_cnt[k] = r_cnt[k] - 1'b1;
            end else begin
                n_cnt[k] = r_cnt[k];
            end
        end
    end

    assign jidx   = i_restart ? 3'd0 : jump;
    assign n_addr = i_restart ? '0
                  : r_addr + ADDR_WIDTH'(signed'(i_jumps[jidx]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            for (int k = 0; k < LEVELS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_fire) begin
            r_addr <= n_addr;
            for (int k = 0; k < LEVELS; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    assign o_addr         = r_addr;
    assign o_step.fire    = i_fire;
    assign o_step.restart = i_restart;
    assign o_step.jump    = jump;

    a_restart_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_restart |=> r_addr == '0)
        else $error("address not cleared by restart");

    a_outer_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_restart && jump == JMP_OUTER
        |=> r_cnt[0] == $past(len[0]) && r_cnt[3] == $past(len[3]))
        else $error("outer jump did not reload the nest");

endmodule

// File: hdl/nla_zigzag.sv
// Zig-zag stepper for the input/weight bit-plane offsets.
module nla_zigzag (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nla_pkg::t_step               i_step,
    input  nla_pkg::t_zz_cfg             i_cfg,
    output logic [nla_pkg::PLANE_W-1:0]  o_in_plane,
    output logic [nla_pkg::PLANE_W-1:0]  o_wt_plane,
    output logic                         o_stepped
);
    import nla_pkg::*;

    logic [PLANE_W-1:0] r_d;
    logic [PLANE_W-1:0] r_w;
    logic [PLANE_W-1:0] n_d;
    logic [PLANE_W-1:0] n_w;
    logic [PLANE_W-1:0] st_d;
    logic [PLANE_W-1:0] st_w;
    logic [7:0]         sel_ext;
    logic [5:0]         s;
    logic [5:0]         lim;
    logic [5:0]         q;
    logic [5:0]         d_hi;
    logic               stepped;

    assign sel_ext = {{(8 - SEL_W){1'b0}}, i_cfg.select};
    assign stepped = i_step.fire && !i_step.restart && sel_ext[i_step.jump];

    assign q   = {2'b00, i_cfg.prec_wt} + 6'd1;
    assign s   = {2'b00, r_w} + {2'b00, r_d} + 6'd1;
    assign lim = {2'b00, i_cfg.prec_in} + {2'b00, i_cfg.prec_wt} + 6'd1;
    assign d_hi = s - q + 6'd1;

    always_comb begin
        if (r_w == '0 || r_d == i_cfg.prec_in) begin
            if (s >= lim) begin
                st_d = '0;
                st_w = '0;
            end else if (s >= q) begin
                st_d = d_hi[PLANE_W-1:0];
                st_w = i_cfg.prec_wt;
            end else begin
                st_d = '0;
                st_w = s[PLANE_W-1:0];
            end
        end else begin
            st_d = r_d + 1'b1;
            st_w = r_w - 1'b1;
        end
    end

    always_comb begin
        if (i_step.fire && i_step.restart) begin
            n_d = '0;
            n_w = '0;
        end else if (stepped) begin
            n_d = st_d;
            n_w = st_w;
        end else begin
            n_d = r_d;
            n_w = r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
            r_w <= '0;
        end else begin
            r_d <= n_d;
            r_w <= n_w;
        end
    end

    assign o_in_plane = n_d;
    assign o_wt_plane = n_w;
    assign o_stepped  = stepped;

    a_planes_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !stepped && !(i_step.fire && i_step.restart)
        |=> $stable(r_d) && $stable(r_w))
        else $error("planes moved without a step");

endmodule

// File: hdl/nested_loop_address_generator_top.sv
// Nested-loop address generator top: configuration registers and result register.
// One request enters per clock: the counter nest, address add and plane stepper
// settle combinationally from their state registers, and the result is captured
// in an output register when the request is accepted. s_axis_tready stays high while
// that register is empty or being drained, so the sustained rate is one result
// per clock; only a stalled m_axis_tready throttles it.
// All counters reset to zero, so a first non-restart step takes the outer jump.
module nested_loop_address_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [nla_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nla_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] restart, [7:1] zero
    input  logic [nla_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [23:0] address, [26:24] jump_taken, [30:27] input_bit_offset,
    // [34:31] weight_bit_offset, [35] zigzag_stepped, [39:36] zero
    output logic [nla_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import nla_pkg::*;

    logic [CFG_W-1:0]   r_lengths;
    logic [JUMP_W-1:0]  r_jumps [JUMP_COUNT];
    logic [SEL_W-1:0]   r_select;
    logic [PREC_W-1:0]  r_prec;

    logic               fire;
    logic               restart;
    logic [ADDR_WIDTH-1:0] addr;
    t_step              step;
    t_zz_cfg            zz_cfg;
    logic [PLANE_W-1:0] in_plane;
    logic [PLANE_W-1:0] wt_plane;
    logic               stepped;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lengths <= '0;
            r_select  <= '0;
            r_prec    <= '0;
            for (int k = 0; k < JUMP_COUNT; k++) begin
                r_jumps[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_LENGTHS:    r_lengths  <= i_cfg_data;
                REG_JUMP_OUTER: r_jumps[0] <= i_cfg_data[JUMP_W-1:0];
                REG_JUMP_L1:    r_jumps[1] <= i_cfg_data[JUMP_W-1:0];
                REG_JUMP_L2:    r_jumps[2] <= i_cfg_data[JUMP_W-1:0];
                REG_JUMP_L3:    r_jumps[3] <= i_cfg_data[JUMP_W-1:0];
                REG_JUMP_INNER: r_jumps[4] <= i_cfg_data[JUMP_W-1:0];
                REG_ZZ_SELECT:  r_select   <= i_cfg_data[SEL_W-1:0];
                REG_PRECISIONS: r_prec     <= i_cfg_data[PREC_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign zz_cfg.select  = r_select;
    assign zz_cfg.prec_in = r_prec[PLANE_W-1:0];
    assign zz_cfg.prec_wt = r_prec[PREC_W-1:PLANE_W];

    nla_nest u_nest (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_restart (restart),
        .i_lengths (r_lengths),
        .i_jumps   (r_jumps),
        .o_addr    (addr),
        .o_step    (step)
    );

    nla_zigzag u_zigzag (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_cfg      (zz_cfg),
        .o_in_plane (in_plane),
        .o_wt_plane (wt_plane),
        .o_stepped  (stepped)
    );

    assign n_out_data = {4'b0000, stepped, wt_plane, in_plane, step.jump,
                         ADDR_FIELD_W'(addr)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid && r_out_data[26:24] == $past(step.jump))
        else $error("accepted request not presented");

endmodule

// File: sim/nla_step_checker.sv
// Checker for the nested-loop address generator: predicts every result and compares it.
module nla_step_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nla_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nla_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    // [0] restart, [7:1] zero
    input  logic [nla_pkg::IN_TDATA_W-1:0]   i_req_data,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    // [23:0] address, [26:24] jump_taken, [30:27] input_bit_offset,
    // [34:31] weight_bit_offset, [35] zigzag_stepped, [39:36] zero
    input  logic [nla_pkg::OUT_TDATA_W-1:0]  i_res_data,
    output int                               o_pending,
    output int                               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import nla_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [3:0]              pad;
        logic                    stepped;
        logic [PLANE_W-1:0]      wt_offset;
        logic [PLANE_W-1:0]      in_offset;
        t_jump                   jump;
        logic [ADDR_FIELD_W-1:0] addr;
    } t_step_result;

    // register copies
    logic [CFG_W-1:0]                    lengths_cfg = '0;
    logic [JUMP_COUNT-1:0][JUMP_W-1:0]   jump_cfg    = '0;
    logic [SEL_W-1:0]                    select_cfg  = '0;
    logic [PREC_W-1:0]                   prec_cfg    = '0;

    // generator state
    logic [COUNT_WIDTH-1:0] level_count [LEVELS];
    logic [ADDR_WIDTH-1:0]  addr_now = '0;
    logic [PLANE_W-1:0]     in_plane = '0;
    logic [PLANE_W-1:0]     wt_plane = '0;

    t_step_result predicted_steps[$];
    int           fails = 0;

    initial begin
        foreach (level_count[k]) level_count[k] = '0;
    end

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        if (fails < PRINT_CAP)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        fails++;
    endtask

    function automatic logic [COUNT_WIDTH-1:0] reload_value(int level);
        return lengths_cfg[LEN_FIELD_W*level +: COUNT_WIDTH];
    endfunction

    // one move along the zig-zag over (input, weight) bit-plane pairs
    function automatic void advance_planes();
        int p, q, d, w, s;
        p = int'(prec_cfg[PLANE_W-1:0]) + 1;
        q = int'(prec_cfg[PREC_W-1:PLANE_W]) + 1;
        d = int'(in_plane);
        w = int'(wt_plane);
        if (w == 0 || d == p - 1) begin
            s = w + d + 1;
            if (s >= p + q - 1) begin
                d = 0;
                w = 0;
            end else if (s >= q) begin
                d = s - q + 1;
                w = q - 1;
            end else begin
                d = 0;
                w = s;
            end
        end else begin
            d = d + 1;
            w = w - 1;
        end
        in_plane = PLANE_W'(d);
        wt_plane = PLANE_W'(w);
    endfunction

    function automatic t_step_result step_nest(logic restart);
        t_step_result r;
        int           top;
        r      = '0;
        r.addr = addr_now;
        if (restart) begin
            for (int k = 0; k < LEVELS; k++) level_count[k] = reload_value(k);
            addr_now = '0;
            in_plane = '0;
            wt_plane = '0;
            r.jump   = JMP_RESTART;
        end else begin
            // top-1 is the innermost nonzero level; zero means the whole nest ran out
            top = LEVELS;
            while (top > 0 && level_count[top-1] == '0) top--;
            for (int k = top; k < LEVELS; k++) level_count[k] = reload_value(k);
            if (top > 0) level_count[top-1] = level_count[top-1] - 1'b1;
            r.jump   = t_jump'(top);
            addr_now = addr_now + ADDR_WIDTH'(signed'(jump_cfg[top]));
            if (select_cfg[top]) begin
                advance_planes();
                r.stepped = 1'b1;
            end
        end
        r.in_offset = in_plane;
        r.wt_offset = wt_plane;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_step_result got, want;
        if (!i_rst_n) begin
            lengths_cfg = '0;
            jump_cfg    = '0;
            select_cfg  = '0;
            prec_cfg    = '0;
            foreach (level_count[k]) level_count[k] = '0;
            addr_now = '0;
            in_plane = '0;
            wt_plane = '0;
            predicted_steps.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LENGTHS:    lengths_cfg = i_cfg_data;
                    REG_JUMP_OUTER: jump_cfg[JMP_OUTER] = i_cfg_data[JUMP_W-1:0];
                    REG_JUMP_L1:    jump_cfg[JMP_L1]    = i_cfg_data[JUMP_W-1:0];
                    REG_JUMP_L2:    jump_cfg[JMP_L2]    = i_cfg_data[JUMP_W-1:0];
                    REG_JUMP_L3:    jump_cfg[JMP_L3]    = i_cfg_data[JUMP_W-1:0];
                    REG_JUMP_INNER: jump_cfg[JMP_INNER] = i_cfg_data[JUMP_W-1:0];
                    REG_ZZ_SELECT:  select_cfg = i_cfg_data[SEL_W-1:0];
                    REG_PRECISIONS: prec_cfg   = i_cfg_data[PREC_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (predicted_steps.size() == 0) begin
                    report_mismatch("unrequested result", 0, i_res_data);
                end else begin
                    want = predicted_steps.pop_front();
                    if (got.addr != want.addr)
                        report_mismatch("address", want.addr, got.addr);
                    if (got.jump != want.jump)
                        report_mismatch("jump_taken", want.jump, got.jump);
                    if (got.in_offset != want.in_offset)
                        report_mismatch("input_bit_offset", want.in_offset, got.in_offset);
                    if (got.wt_offset != want.wt_offset)
                        report_mismatch("weight_bit_offset", want.wt_offset, got.wt_offset);
                    if (got.stepped != want.stepped)
                        report_mismatch("zigzag_stepped", want.stepped, got.stepped);
                end
            end
            if (i_req_valid && i_req_ready)
                predicted_steps.push_back(step_nest(i_req_data[0]));
        end
        o_pending    <= predicted_steps.size();
        o_fail_count <= fails;
    end

endmodule

// File: sim/testbench.sv
// Testbench top: clock, reset, configuration and request stimulus, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nla_pkg::*;

    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 162;
    localparam int QUIET_LIMIT = 2000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_W-1:0]       i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int pending;
    int fail_count;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    nested_loop_address_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nla_step_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // write enable is left high; the caller lowers it after the last write
    task automatic write_reg(t_cfg_reg idx, logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry noise, the block must ignore them
    task automatic program_registers(logic [CFG_W-1:0] lengths,
                                     logic [JUMP_COUNT-1:0][JUMP_W-1:0] jumps,
                                     logic [SEL_W-1:0] sel, logic [PREC_W-1:0] prec);
        write_reg(REG_LENGTHS, lengths);
        for (int k = 0; k < JUMP_COUNT; k++)
            write_reg(t_cfg_reg'(int'(REG_JUMP_OUTER) + k),
                      {$urandom(), 8'($urandom()), jumps[k]});
        write_reg(REG_ZZ_SELECT, {$urandom(), 27'($urandom()), sel});
        write_reg(REG_PRECISIONS, {$urandom(), 24'($urandom()), prec});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(logic restart);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(restart);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_W-1:0]                  lengths;
        logic [JUMP_COUNT-1:0][JUMP_W-1:0] jumps;
        int                                pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: every non-restart step takes the outer jump of zero
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_results();

        // short nest, extreme jumps so the address wraps, every jump steps the planes
        program_registers({16'd2, 16'd1, 16'd1, 16'd1},
                          {24'h7FFFFF, 24'hFFFFFF, 24'h000001, 24'h7FFFFF, 24'h800000},
                          5'h1F, 8'hFF);
        send_request(1'b1);
        repeat (12) send_request(1'b0);
        wait_for_results();

        // precisions shrink while the planes stand above them
        program_registers({4{16'hFFFF}},
                          {24'h800000, 24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
                          5'b10101, 8'h00);
        repeat (6) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_results();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // mostly short loops so every level wraps often
            for (int lvl = 0; lvl < LEVELS; lvl++) begin
                pick = $urandom_range(31);
                if (pick == 0)
                    lengths[LEN_FIELD_W*lvl +: LEN_FIELD_W] = '1;
                else if (pick == 1)
                    lengths[LEN_FIELD_W*lvl +: LEN_FIELD_W] = LEN_FIELD_W'($urandom());
                else
                    lengths[LEN_FIELD_W*lvl +: LEN_FIELD_W] = LEN_FIELD_W'($urandom_range(3));
            end
            for (int k = 0; k < JUMP_COUNT; k++) begin
                if ($urandom_range(3) == 0)
                    jumps[k] = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
                else
                    jumps[k] = JUMP_W'($urandom());
            end
            program_registers(lengths, jumps, SEL_W'($urandom()), PREC_W'($urandom()));
            case (ph % 4)
                0: begin
                    gap_pct   = 0;
                    stall_pct <= 0;
                end
                1: begin
                    gap_pct   = 76;
                    stall_pct <= 0;
                end
                2: begin
                    gap_pct   = 0;
                    stall_pct <= 76;
                end
                default: begin
                    gap_pct   = 8;
                    stall_pct <= 8;
                end
            endcase
            repeat (PHASE_ITEMS) send_request($urandom_range(39) == 0);
            wait_for_results();
        end

        repeat (6) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/nla_pkg.sv
hdl/nla_nest.sv
hdl/nla_zigzag.sv
hdl/nested_loop_address_generator_top.sv
sim/nla_step_checker.sv
sim/testbench.sv
